// ===== rtl/core/tbs_pkg.sv =====
`timescale 1ns / 1ps

package tbs_pkg;

  localparam int unsigned TiltW   = 16;
  localparam int unsigned DriveW  = 16;
  localparam int unsigned PhaseW  = 3;
  localparam int unsigned SpeedW  = 15;
  localparam int unsigned AngleW  = 15;
  localparam int unsigned TicksW  = 10;
  localparam int unsigned CountW  = 12;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDatW = 16;

  localparam logic [CountW-1:0] CountMax       = {CountW{1'b1}};
  localparam logic [CountW-1:0] DoubleTapTicks = CountW'(15);

  // phase codes
  localparam logic [PhaseW-1:0] PhScore    = 3'd0;
  localparam logic [PhaseW-1:0] PhApproach = 3'd1;
  localparam logic [PhaseW-1:0] PhClimb    = 3'd2;
  localparam logic [PhaseW-1:0] PhSettle   = 3'd3;
  localparam logic [PhaseW-1:0] PhDone     = 3'd4;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegMode      = 4'd0;
  localparam logic [CfgIdxW-1:0] RegSpeedFast = 4'd1;
  localparam logic [CfgIdxW-1:0] RegSpeedSlow = 4'd2;
  localparam logic [CfgIdxW-1:0] RegOnStation = 4'd3;
  localparam logic [CfgIdxW-1:0] RegLevel     = 4'd4;
  localparam logic [CfgIdxW-1:0] RegDebounce  = 4'd5;
  localparam logic [CfgIdxW-1:0] RegTap       = 4'd6;
  localparam logic [CfgIdxW-1:0] RegBackup    = 4'd7;

  typedef struct packed {
    logic [0:0]        mode;
    logic [SpeedW-1:0] speed_fast;
    logic [SpeedW-1:0] speed_slow;
    logic [AngleW-1:0] on_station_angle;
    logic [AngleW-1:0] level_angle;
    logic [TicksW-1:0] debounce_ticks;
    logic [TicksW-1:0] tap_ticks;
    logic [TicksW-1:0] backup_ticks;
  } cfg_t;

endpackage

// ===== rtl/core/tbs_if.sv =====
`timescale 1ns / 1ps

interface tbs_tilt_if;
  import tbs_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [TiltW-1:0]  tilt;
  modport source (output valid, output tilt, input ready);
  modport sink   (input valid, input tilt, output ready);
endinterface

interface tbs_res_if;
  import tbs_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DriveW-1:0] drive;
  logic [PhaseW-1:0]        phase;
  logic                     done_res;
  modport source (output valid, output drive, output phase, output done_res, input ready);
  modport sink   (input valid, input drive, input phase, input done_res, output ready);
endinterface

interface tbs_cfg_if;
  import tbs_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CfgIdxW-1:0]   index;
  logic [CfgDatW-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/tilt_balance_sequencer_top.sv =====
`timescale 1ns / 1ps

// tilt balance sequencer: one transaction per control tick
// tilt_i   : input channel, one signed tilt angle (1/128 degree) per transaction
// result_o : output channel, drive speed (Q1.15 signed), phase and done flag
// cfg_i    : register write channel, index and data, always ready; write only
//            while no tick is in flight
// a tilt transaction is captured in an input register; when the result register can
// load, the phase/count update and the result are computed from that register and the
// phase and count registers, and land in the result register
// throughput: one tick per cycle while the receiver takes results, set by the phase
// and count update that each tick needs from the one before
// when the receiver stalls, the result register holds, the input register
// fills, and tilt_i.ready drops until the result is taken
// reset: registers take their default values, phase is scoring (acts as
// approach with mode 0), count is zero, both pipeline stages are empty
module tilt_balance_sequencer_top
  import tbs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  tbs_tilt_if.sink    tilt_i,
  tbs_res_if.source   result_o,
  tbs_cfg_if.sink     cfg_i
);

  cfg_t cfg_q;

  // configuration writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode             <= 1'b0;
      cfg_q.speed_fast       <= SpeedW'(13107);
      cfg_q.speed_slow       <= SpeedW'(6554);
      cfg_q.on_station_angle <= AngleW'(1664);
      cfg_q.level_angle      <= AngleW'(768);
      cfg_q.debounce_ticks   <= TicksW'(10);
      cfg_q.tap_ticks        <= TicksW'(20);
      cfg_q.backup_ticks     <= TicksW'(10);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        RegMode:      cfg_q.mode             <= cfg_i.data[0];
        RegSpeedFast: cfg_q.speed_fast       <= cfg_i.data[SpeedW-1:0];
        RegSpeedSlow: cfg_q.speed_slow       <= cfg_i.data[SpeedW-1:0];
        RegOnStation: cfg_q.on_station_angle <= cfg_i.data[AngleW-1:0];
        RegLevel:     cfg_q.level_angle      <= cfg_i.data[AngleW-1:0];
        RegDebounce:  cfg_q.debounce_ticks   <= cfg_i.data[TicksW-1:0];
        RegTap:       cfg_q.tap_ticks        <= cfg_i.data[TicksW-1:0];
        RegBackup:    cfg_q.backup_ticks     <= cfg_i.data[TicksW-1:0];
        default:      ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // pipeline handshakes
  logic                    in_valid_q;
  logic signed [TiltW-1:0] in_tilt_q;
  logic                    out_valid_q;
  logic                    out_load;
  logic                    step_fire;

  assign out_load     = !out_valid_q || result_o.ready;
  assign step_fire    = in_valid_q && out_load;
  assign tilt_i.ready = !in_valid_q || step_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (tilt_i.ready) begin
      in_valid_q <= tilt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tilt_i.ready && tilt_i.valid) begin
      in_tilt_q <= tilt_i.tilt;
    end
  end

  // sequencer state
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [CountW-1:0] count_q, count_d;

  logic [PhaseW-1:0]        eff_phase;
  logic [PhaseW-1:0]        shown_phase;
  logic [CountW-1:0]        count_inc;
  logic [CountW-1:0]        t1, t2, t3;
  logic [CountW-1:0]        debounce;
  logic signed [TiltW:0]    tilt_x;
  logic signed [TiltW:0]    on_station_x;
  logic signed [TiltW:0]    level_x;
  logic [TiltW:0]           mag;
  logic [TiltW+1:0]         mag2;
  logic signed [DriveW-1:0] fast_pos, slow_pos, half_slow;
  logic signed [DriveW-1:0] drive_d;

  assign count_inc    = (count_q == CountMax) ? count_q : count_q + 1'b1;
  assign t1           = CountW'(cfg_q.tap_ticks);
  assign t2           = t1 + CountW'(cfg_q.backup_ticks);
  assign t3           = t2 + DoubleTapTicks;
  assign debounce     = CountW'(cfg_q.debounce_ticks);
  assign tilt_x       = (TiltW+1)'(in_tilt_q);
  assign on_station_x = $signed({2'b00, cfg_q.on_station_angle});
  assign level_x      = $signed({2'b00, cfg_q.level_angle});
  assign mag          = tilt_x[TiltW] ? (TiltW+1)'(-tilt_x) : (TiltW+1)'(tilt_x);
  assign mag2         = {mag, 1'b0};
  assign fast_pos     = $signed({1'b0, cfg_q.speed_fast});
  assign slow_pos     = $signed({1'b0, cfg_q.speed_slow});
  assign half_slow    = $signed({2'b00, cfg_q.speed_slow[SpeedW-1:1]});

  // in balance-only mode the scoring phase is skipped, but the stored code
  // stays at scoring until approach is left
  assign eff_phase = (phase_q == PhScore && !cfg_q.mode) ? PhApproach : phase_q;

  always_comb begin
    logic [CountW-1:0] c;
    c       = count_q;
    phase_d = phase_q;
    count_d = count_q;
    drive_d = '0;
    unique case (eff_phase)
      PhScore: begin
        count_d = count_inc;
        if (count_inc < t1) begin
          drive_d = -fast_pos;
        end else if (count_inc < t2) begin
          drive_d = fast_pos;
        end else if (count_inc < t3) begin
          drive_d = -fast_pos;
        end else begin
          count_d = '0;
          phase_d = PhApproach;
        end
      end
      PhApproach: begin
        c = (tilt_x > on_station_x) ? count_inc : count_q;
        count_d = c;
        if (c > debounce) begin
          phase_d = PhClimb;
          count_d = '0;
          drive_d = slow_pos;
        end else begin
          drive_d = fast_pos;
        end
      end
      PhClimb: begin
        c = (tilt_x < level_x) ? count_inc : count_q;
        count_d = c;
        if (c > debounce) begin
          phase_d = PhSettle;
          count_d = '0;
        end else begin
          drive_d = slow_pos;
        end
      end
      PhSettle: begin
        // level test on the exact half of level_angle
        c = (mag2 <= {2'b00, level_x[TiltW-1:0]}) ? count_inc : count_q;
        count_d = c;
        if (c > debounce) begin
          phase_d = PhDone;
          count_d = '0;
        end else if (tilt_x >= level_x) begin
          drive_d = half_slow;
        end else if (tilt_x <= -level_x) begin
          drive_d = -half_slow;
        end
      end
      default: ;  // done and unused codes drive zero
    endcase
  end

  always_comb begin
    shown_phase = phase_d;
    if (phase_d == PhScore && !cfg_q.mode) begin
      shown_phase = PhApproach;
    end else if (phase_d > PhDone) begin
      shown_phase = PhDone;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhScore;
      count_q <= '0;
    end else if (step_fire) begin
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

  // result register
  logic signed [DriveW-1:0] out_drive_q;
  logic [PhaseW-1:0]        out_phase_q;
  logic                     out_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      out_drive_q <= drive_d;
      out_phase_q <= shown_phase;
      out_done_q  <= (shown_phase == PhDone);
    end
  end

  assign result_o.valid    = out_valid_q;
  assign result_o.drive    = out_drive_q;
  assign result_o.phase    = out_phase_q;
  assign result_o.done_res = out_done_q;

  // checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_done_q == (out_phase_q == PhDone)))
    else $error("done flag disagrees with reported phase");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_fire |=> $stable(phase_q) && $stable(count_q))
    else $error("sequencer state moved without a tick");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_fire && phase_d != phase_q && eff_phase != PhScore) |=> (count_q == '0))
    else $error("count not cleared on phase change");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !result_o.ready) |=> out_valid_q && $stable(out_drive_q))
    else $error("stalled result lost");

endmodule

// ===== bench/tilt_balance_sequencer_top_tb.sv =====
`timescale 1ns / 1ps

module tilt_balance_sequencer_top_tb;
  import tbs_pkg::*;

  // stimulus ranges taken from the field widths
  localparam int TiltMin  = -(2 ** (TiltW - 1));
  localparam int TiltMax  = 2 ** (TiltW - 1) - 1;
  localparam int SpeedMax = 2 ** SpeedW - 1;
  localparam int AngleMax = 2 ** AngleW - 1;
  localparam int TicksMax = 2 ** TicksW - 1;

  // extra wait after the last result comes back, as margin
  localparam int DrainCycles = 4;
  // longest legal silence is the receiver hold-off
  localparam int WatchdogCycles = 2000;
  localparam int HoldOffCycles  = 300;

  typedef struct packed {
    logic [DriveW-1:0] drive;
    logic [PhaseW-1:0] phase;
    logic              done_res;
  } tick_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  tbs_tilt_if tilt_ch ();
  tbs_res_if  res_ch ();
  tbs_cfg_if  cfg_ch ();

  tilt_balance_sequencer_top dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .tilt_i   (tilt_ch),
    .result_o (res_ch),
    .cfg_i    (cfg_ch)
  );

  always #4 clk = ~clk;

  // shadow of the block: register file, phase and debounce count
  cfg_t              regs;
  logic [PhaseW-1:0] bal_phase;
  logic [CountW-1:0] bal_count;

  tick_result_t expected_ticks[$];
  int           mismatches  = 0;
  int           idle_cycles = 0;

  // stimulus side knobs
  bit tx_idling = 1'b0;
  bit rx_idling = 1'b0;
  int hold_req  = 0;
  // qualifying ticks sent since the current sensed phase was entered,
  // mirrors the debounce count so exits can be steered
  int qual_ticks = 0;

  function automatic void bump_count();
    if (bal_count != CountMax) bal_count++;
  endfunction

  // next drive, phase and done flag for one tick; updates phase and count
  function automatic tick_result_t advance_balance(input logic signed [TiltW-1:0] tilt);
    int                t;
    int                lvl;
    int                mag;
    int                drv;
    int                cnt;
    int                t2;
    int                t3;
    int                slow;
    int                fast;
    logic [PhaseW-1:0] eff;
    logic [PhaseW-1:0] shown;
    tick_result_t      r;
    t    = tilt;
    lvl  = int'(regs.level_angle);
    slow = int'(regs.speed_slow);
    fast = int'(regs.speed_fast);
    drv  = 0;
    eff  = bal_phase;
    // scoring phase only runs with mode set, otherwise it behaves as approach
    if (eff == PhScore && regs.mode == 1'b0) eff = PhApproach;
    case (eff)
      PhScore: begin
        bump_count();
        cnt = int'(bal_count);
        t2  = int'(regs.tap_ticks) + int'(regs.backup_ticks);
        t3  = t2 + int'(DoubleTapTicks);
        if (cnt < int'(regs.tap_ticks)) begin
          drv = -fast;
        end else if (cnt < t2) begin
          drv = fast;
        end else if (cnt < t3) begin
          drv = -fast;
        end else begin
          bal_count = '0;
          bal_phase = PhApproach;
          drv       = 0;
        end
      end
      PhApproach: begin
        if (t > int'(regs.on_station_angle)) bump_count();
        if (int'(bal_count) > int'(regs.debounce_ticks)) begin
          bal_phase = PhClimb;
          bal_count = '0;
          drv       = slow;
        end else begin
          drv = fast;
        end
      end
      PhClimb: begin
        if (t < lvl) bump_count();
        if (int'(bal_count) > int'(regs.debounce_ticks)) begin
          bal_phase = PhSettle;
          bal_count = '0;
          drv       = 0;
        end else begin
          drv = slow;
        end
      end
      PhSettle: begin
        mag = (t < 0) ? -t : t;
        // level window is half of level_angle, compared without rounding
        if (2 * mag <= lvl) bump_count();
        if (int'(bal_count) > int'(regs.debounce_ticks)) begin
          bal_phase = PhDone;
          bal_count = '0;
          drv       = 0;
        end else if (t >= lvl) begin
          drv = slow / 2;
        end else if (t <= -lvl) begin
          drv = -(slow / 2);
        end else begin
          drv = 0;
        end
      end
      default: drv = 0;
    endcase
    shown = bal_phase;
    if (shown == PhScore && regs.mode == 1'b0) shown = PhApproach;
    if (shown > PhDone) shown = PhDone;
    r.drive    = drv[DriveW-1:0];
    r.phase    = shown;
    r.done_res = (shown == PhDone);
    return r;
  endfunction

  function automatic void write_shadow(input logic [CfgIdxW-1:0] idx,
                                       input logic [CfgDatW-1:0] word);
    case (idx)
      RegMode:      regs.mode             = word[0];
      RegSpeedFast: regs.speed_fast       = word[SpeedW-1:0];
      RegSpeedSlow: regs.speed_slow       = word[SpeedW-1:0];
      RegOnStation: regs.on_station_angle = word[AngleW-1:0];
      RegLevel:     regs.level_angle      = word[AngleW-1:0];
      RegDebounce:  regs.debounce_ticks   = word[TicksW-1:0];
      RegTap:       regs.tap_ticks        = word[TicksW-1:0];
      RegBackup:    regs.backup_ticks     = word[TicksW-1:0];
      default: ;
    endcase
  endfunction

  // one place that watches all three channels at the rising edge:
  // results are checked, tilt transactions predicted, writes shadowed
  always @(posedge clk) begin : channel_monitor
    bit           busy;
    tick_result_t want;
    busy = 1'b0;
    if (rst_n) begin
      if (res_ch.valid && res_ch.ready) begin
        busy = 1'b1;
        if (expected_ticks.size() == 0) begin
          $display("%0t: unexpected result drive %0d phase %0d done %0b", $time,
                   $signed(res_ch.drive), res_ch.phase, res_ch.done_res);
          mismatches++;
        end else begin
          want = expected_ticks.pop_front();
          if (res_ch.drive !== want.drive) begin
            $display("%0t: drive expected %0d got %0d", $time,
                     $signed(want.drive), $signed(res_ch.drive));
            mismatches++;
          end
          if (res_ch.phase !== want.phase) begin
            $display("%0t: phase expected %0d got %0d", $time, want.phase, res_ch.phase);
            mismatches++;
          end
          if (res_ch.done_res !== want.done_res) begin
            $display("%0t: done expected %0b got %0b", $time, want.done_res,
                     res_ch.done_res);
            mismatches++;
          end
        end
      end
      if (tilt_ch.valid && tilt_ch.ready) begin
        busy = 1'b1;
        expected_ticks.push_back(advance_balance(tilt_ch.tilt));
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        busy = 1'b1;
        write_shadow(cfg_ch.index, cfg_ch.data);
      end
      idle_cycles = busy ? 0 : idle_cycles + 1;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result receiver: a requested hold-off first, then random stalls
  initial begin
    int stall_left;
    stall_left   = 0;
    res_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        res_ch.ready <= 1'b0;
        hold_req--;
      end else if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        res_ch.ready <= 1'b1;
        if (rx_idling && $urandom_range(0, 3) == 0) stall_left = gap_len();
      end
    end
  end

  // ends the run when no transaction of any kind moves for too long
  initial begin
    while (idle_cycles < WatchdogCycles) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  // offer one tilt, with an optional gap of noise in front, and wait for it to go
  task automatic send_tilt(input logic signed [TiltW-1:0] value);
    int gap;
    gap = tx_idling ? gap_len() : 0;
    repeat (gap) begin
      @(negedge clk);
      tilt_ch.valid <= 1'b0;
      tilt_ch.tilt  <= TiltW'($urandom);
    end
    @(negedge clk);
    tilt_ch.valid <= 1'b1;
    tilt_ch.tilt  <= value;
    @(posedge clk);
    while (!tilt_ch.ready) @(posedge clk);
  endtask

  // random upper bits ride along above the field, the block must drop them
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int value, input int width);
    logic [CfgDatW-1:0] mask;
    logic [CfgDatW-1:0] word;
    mask = CfgDatW'((32'd1 << width) - 1);
    word = CfgDatW'($urandom);
    word = (word & ~mask) | (CfgDatW'(value) & mask);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= word;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // stop offering and let every outstanding tick come back
  task automatic drain_results();
    @(negedge clk);
    tilt_ch.valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic logic [CfgIdxW-1:0] unused_index();
    return CfgIdxW'(int'(RegBackup) + 1 + $urandom_range(0, 7));
  endfunction

  function automatic int reg_value(input int top);
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return top;
      default: return $urandom_range(0, top);
    endcase
  endfunction

  // tilt that does or does not advance the debounce count of the given phase;
  // qual comes back cleared when no qualifying tilt exists
  function automatic logic signed [TiltW-1:0] pick_tilt(input logic [PhaseW-1:0] ph,
                                                        inout bit qual);
    int os;
    int lvl;
    int half;
    int lo;
    int hi;
    int v;
    int r;
    os   = int'(regs.on_station_angle);
    lvl  = int'(regs.level_angle);
    half = lvl / 2;
    lo   = TiltMin;
    hi   = TiltMax;
    case (ph)
      PhApproach: begin
        if (qual && os < TiltMax) begin
          lo = os + 1;
        end else begin
          qual = 1'b0;
          hi   = os;
        end
      end
      PhClimb: begin
        if (qual) hi = lvl - 1;
        else lo = lvl;
      end
      PhSettle: begin
        if (qual) begin
          lo = -half;
          hi = half;
        end else if ($urandom_range(0, 1) == 1) begin
          lo = half + 1;
        end else begin
          hi = -half - 1;
        end
      end
      default: ;
    endcase
    r = $urandom_range(0, 7);
    if (r == 0) v = lo;
    else if (r == 1) v = hi;
    else v = lo + int'($urandom_range(0, hi - lo));
    return TiltW'(v);
  endfunction

  // everything except the debounce limit, which the phase runs steer themselves
  task automatic shuffle_registers();
    write_reg(RegMode, $urandom_range(0, 1), 1);
    write_reg(RegSpeedFast, reg_value(SpeedMax), SpeedW);
    write_reg(RegSpeedSlow, reg_value(SpeedMax), SpeedW);
    write_reg(RegOnStation, reg_value(AngleMax), AngleW);
    write_reg(RegLevel, reg_value(AngleMax), AngleW);
    write_reg(RegTap, reg_value(TicksMax), TicksW);
    write_reg(RegBackup, reg_value(TicksMax), TicksW);
    if ($urandom_range(0, 3) == 0) write_reg(unused_index(), $urandom, CfgDatW);
  endtask

  // random ticks inside one phase, in chunks with new settings between them;
  // the debounce limit sits at its maximum so the phase is never left here
  task automatic run_phase(input logic [PhaseW-1:0] ph, input int n_items);
    int                      left;
    int                      chunk;
    int                      pct;
    bit                      q;
    logic signed [TiltW-1:0] t;
    left = n_items;
    while (left > 0) begin
      chunk = $urandom_range(25, 70);
      if (chunk > left) chunk = left;
      pct       = $urandom_range(10, 60);
      // on each side, about one chunk in four runs without gaps
      tx_idling = ($urandom_range(0, 3) != 0);
      rx_idling = ($urandom_range(0, 3) != 0);
      repeat (chunk) begin
        q = ($urandom_range(0, 99) < pct);
        t = pick_tilt(ph, q);
        send_tilt(t);
        if (q) qual_ticks++;
      end
      left -= chunk;
      drain_results();
      shuffle_registers();
    end
  endtask

  // lower the debounce limit and feed the phase until the count passes it;
  // a limit below the count already reached makes the next tick leave
  task automatic exit_phase(input logic [PhaseW-1:0] ph, input int deb);
    bit                      q;
    logic signed [TiltW-1:0] t;
    drain_results();
    write_reg(RegOnStation, $urandom_range(0, AngleMax - 1), AngleW);
    write_reg(RegDebounce, deb, TicksW);
    do begin
      q = (qual_ticks <= deb) ? 1'b1 : bit'($urandom_range(0, 1));
      t = pick_tilt(ph, q);
      send_tilt(t);
      if (q) qual_ticks++;
    end while (qual_ticks <= deb);
    qual_ticks = 0;
  endtask

  // mode 0 out of reset: phase zero shows as approach, boundary tilt does not count
  task automatic test_reset_approach();
    send_tilt(TiltW'(TiltMin));
    send_tilt(TiltW'(1664));
  endtask

  // scoring taps, mode flipped mid-run with the count carried over,
  // tap and backup at both extremes, then the timed exit to approach
  task automatic test_scoring_sequence();
    drain_results();
    for (int i = int'(RegBackup) + 1; i < 2 ** CfgIdxW; i++) begin
      write_reg(CfgIdxW'(i), $urandom, CfgDatW);
    end
    write_reg(RegMode, 1, 1);
    write_reg(RegSpeedFast, SpeedMax, SpeedW);
    write_reg(RegTap, 2, TicksW);
    write_reg(RegBackup, 1, TicksW);
    repeat (3) send_tilt(TiltW'($urandom));
    drain_results();
    write_reg(RegMode, 0, 1);
    send_tilt(TiltW'(TiltMax));
    drain_results();
    write_reg(RegMode, 1, 1);
    write_reg(RegTap, 0, TicksW);
    write_reg(RegBackup, TicksMax, TicksW);
    send_tilt(TiltW'($urandom));
    drain_results();
    write_reg(RegTap, TicksMax, TicksW);
    write_reg(RegBackup, 0, TicksW);
    send_tilt(TiltW'($urandom));
    drain_results();
    write_reg(RegTap, 0, TicksW);
    // count runs from 7 up to the fixed double tap length, last tick leaves
    repeat (9) send_tilt(TiltW'($urandom));
    qual_ticks = 0;
  endtask

  task automatic test_random_approach();
    drain_results();
    write_reg(RegDebounce, TicksMax, TicksW);
    run_phase(PhApproach, 340);
    exit_phase(PhApproach, $urandom_range(0, qual_ticks + 3));
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    bit                      q;
    logic signed [TiltW-1:0] t;
    drain_results();
    tx_idling = 1'b0;
    hold_req  = HoldOffCycles;
    repeat (40) begin
      q = ($urandom_range(0, 1) == 1);
      t = pick_tilt(PhClimb, q);
      send_tilt(t);
      if (q) qual_ticks++;
    end
  endtask

  task automatic test_random_climb();
    drain_results();
    write_reg(RegDebounce, TicksMax, TicksW);
    run_phase(PhClimb, 300);
    test_backpressure();
    exit_phase(PhClimb, 0);
  endtask

  // level window edges with even, odd and zero level angle; odd slow speed
  task automatic test_settle_edges();
    drain_results();
    write_reg(RegDebounce, TicksMax, TicksW);
    write_reg(RegSpeedSlow, SpeedMax, SpeedW);
    write_reg(RegLevel, 1000, AngleW);
    send_tilt(TiltW'(500));
    send_tilt(TiltW'(-500));
    send_tilt(TiltW'(501));
    send_tilt(TiltW'(1000));
    send_tilt(TiltW'(-1000));
    send_tilt(TiltW'(999));
    drain_results();
    write_reg(RegLevel, 1001, AngleW);
    send_tilt(TiltW'(500));
    send_tilt(TiltW'(501));
    drain_results();
    // zero level: flat tilt counts as level yet still gets a positive correction
    write_reg(RegLevel, 0, AngleW);
    send_tilt(TiltW'(0));
    qual_ticks = 4;
  endtask

  task automatic test_random_settle();
    drain_results();
    write_reg(RegDebounce, TicksMax, TicksW);
    run_phase(PhSettle, 520);
    exit_phase(PhSettle, $urandom_range(0, qual_ticks + 3));
  endtask

  // done is final: any tilt and any setting keep drive at zero
  task automatic test_done_hold();
    run_phase(PhDone, 100);
  endtask

  initial begin
    tilt_ch.valid = 1'b0;
    tilt_ch.tilt  = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = '0;
    cfg_ch.data   = '0;

    regs.mode             = 1'b0;
    regs.speed_fast       = SpeedW'(13107);
    regs.speed_slow       = SpeedW'(6554);
    regs.on_station_angle = AngleW'(1664);
    regs.level_angle      = AngleW'(768);
    regs.debounce_ticks   = TicksW'(10);
    regs.tap_ticks        = TicksW'(20);
    regs.backup_ticks     = TicksW'(10);
    bal_phase             = PhScore;
    bal_count             = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_approach();
    test_scoring_sequence();
    test_random_approach();
    test_random_climb();
    test_settle_edges();
    test_random_settle();
    test_done_hold();

    drain_results();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
